>>> design/scpr_pkg.sv
// Shared types, constants and helpers for the second chance page replacement block.
`timescale 1ns / 1ps

package scpr_pkg;

  // Field widths fixed by the access and result words
  localparam int PAGE_W      = 20;
  localparam int FRAME_W     = 6;
  localparam int COUNT_W     = 32;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 1;

  // Match bits examined per search cycle
  localparam int GROUP   = 8;
  localparam int GROUP_W = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_POLICY_MODE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_IN_USE = 1'd1;

  // Reset value of the managed frame count
  localparam logic [CFG_DATA_W-1:0] FRAMES_RESET = 7'd64;

  // One page access
  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              is_write;
  } req_t;

  // One access result
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_index;
    logic               evicted;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] total_requests;
    logic [COUNT_W-1:0] total_faults;
    logic [COUNT_W-1:0] total_disk_writes;
  } rsp_t;

  // Broadcast commands from the sequencer to every frame cell
  typedef struct packed {
    logic match_en;  // latch the compare against the key
    logic fill;      // install the key in the target frame
    logic touch;     // hit update of the target frame
    logic scan;      // clock step at the cell holding the hand
    logic advance;   // victim cell hands the hand on
    logic tok_home;  // put the hand back at frame zero
    logic enhanced;  // dirty-aware policy
    logic wr;        // access is a write
  } cell_cmd_t;

  // Status returned by each frame cell
  typedef struct packed {
    logic match;      // registered compare result
    logic tok;        // this cell holds the clock hand
    logic pass_next;  // hand moves to the next cell
    logic pass_wrap;  // hand wraps back to frame zero
    logic victim;     // hand stops here
    logic stray;      // hand sits at or above the capacity
  } cell_stat_t;

  // Saturating increment of a counter
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + COUNT_W'(1);
  endfunction

  // Position of the lowest set bit in a group
  function automatic logic [GROUP_W-1:0] first_set(input logic [GROUP-1:0] bits);
    logic [GROUP_W-1:0] pos;
    pos = '0;
    for (int i = GROUP - 1; i >= 0; i--) begin
      if (bits[i]) pos = GROUP_W'(i);
    end
    return pos;
  endfunction

endpackage

>>> design/scpr_if.sv
// Valid/ready channels for page access words and result words.
`timescale 1ns / 1ps

interface scpr_req_if;
  logic           valid;
  logic           ready;
  scpr_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scpr_rsp_if;
  logic           valid;
  logic           ready;
  scpr_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/second_chance_page_replacement_top.sv
// Top level: frame cell row, lookup and clock sequencer, counters and result register.
// Sequence: a hit goes from accept through the match latch, a search up to matching group g (1..ceil(F/8)),
// touch and result. A miss searches all ceil(F/8) groups; a free-frame fill then ends like a hit at the last
// group, while an eviction adds a hand check and a clock walk before the fill.
// Throughput: one access at a time; a new access is taken while the last result waits.
// Reset (synchronous): all bits clear, hand at frame 0, counters zero, 64 frames, plain mode.
`timescale 1ns / 1ps

module second_chance_page_replacement_top #(
  parameter int FRAME_COUNT = 64,
  parameter int PAGE_BITS   = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [scpr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [scpr_pkg::CFG_DATA_W-1:0]      cfg_data,
  scpr_req_if.sink                             req,
  scpr_rsp_if.source                           rsp
);

  localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CAP_W = $clog2(FRAME_COUNT + 1);
  localparam int NG    = (FRAME_COUNT + scpr_pkg::GROUP - 1) / scpr_pkg::GROUP;
  localparam int GW    = (NG > 1) ? $clog2(NG) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_TOUCH  = 3'd3;
  localparam logic [2:0] S_HAND   = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_FILL   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  // Control state
  logic [2:0]                      state;
  logic [GW-1:0]                   grp;
  logic [CAP_W-1:0]                filled;
  logic                            policy_mode;
  logic [scpr_pkg::CFG_DATA_W-1:0] frames_in_use;
  logic [scpr_pkg::COUNT_W-1:0]    req_cnt;
  logic [scpr_pkg::COUNT_W-1:0]    fault_cnt;
  logic [scpr_pkg::COUNT_W-1:0]    disk_cnt;
  logic                            rsp_valid;

  // Per-access payload
  logic [PAGE_BITS-1:0]            key;
  logic                            wr_r;
  logic [IDX_W-1:0]                slot;
  logic                            hit_r;
  logic                            evicted_r;
  logic [PAGE_BITS-1:0]            old_page;
  scpr_pkg::rsp_t                  rsp_data;

  // Cell row wiring
  scpr_pkg::cell_cmd_t             cmd;
  scpr_pkg::cell_stat_t            stat [FRAME_COUNT];
  logic [PAGE_BITS-1:0]            cell_page [FRAME_COUNT];
  logic [FRAME_COUNT-1:0]          tok_in;
  logic [FRAME_COUNT-1:0]          tok_vec;
  logic [FRAME_COUNT-1:0]          victim_vec;
  logic                            wrap_any;
  logic                            stray_any;
  logic [IDX_W-1:0]                victim_idx;
  logic [PAGE_BITS-1:0]            victim_page;
  logic [NG*scpr_pkg::GROUP-1:0]   mvec;
  logic [scpr_pkg::GROUP-1:0]      grp_bits;

  logic [CAP_W-1:0]                cap;
  logic [CAP_W-1:0]                live;
  logic                            out_free;
  logic [scpr_pkg::COUNT_W-1:0]    req_next;
  logic [scpr_pkg::COUNT_W-1:0]    fault_next;
  logic [scpr_pkg::COUNT_W-1:0]    disk_next;

  // Clamp the managed frame count to 1..FRAME_COUNT
  always_comb begin
    if (frames_in_use == '0) begin
      cap = CAP_W'(1);
    end else if (32'(frames_in_use) > FRAME_COUNT) begin
      cap = CAP_W'(FRAME_COUNT);
    end else begin
      cap = CAP_W'(frames_in_use);
    end
  end

  assign live = (filled < cap) ? filled : cap;

  // Broadcast commands to the cells
  always_comb begin
    cmd          = '0;
    cmd.enhanced = policy_mode;
    cmd.wr       = wr_r;
    cmd.match_en = (state == S_MATCH);
    cmd.touch    = (state == S_TOUCH);
    cmd.tok_home = (state == S_HAND) && stray_any;
    cmd.scan     = (state == S_SCAN);
    cmd.fill     = (state == S_FILL);
    cmd.advance  = (state == S_FILL) && evicted_r;
  end

  // Row of frame cells; the clock hand travels from each cell to its neighbor
  for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = wrap_any;
    end else begin : g_body
      assign tok_in[i] = stat[i-1].pass_next;
    end

    scpr_cell #(
      .IDX         (i),
      .PAGE_BITS   (PAGE_BITS),
      .IDX_W       (IDX_W),
      .CAP_W       (CAP_W)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .key    (key),
      .target (slot),
      .live   (live),
      .cap    (cap),
      .tok_in (tok_in[i]),
      .stat   (stat[i]),
      .page   (cell_page[i])
    );
  end

  // Gather cell status: hand wrap, stray hand, victim index and page, match bits
  always_comb begin
    wrap_any    = 1'b0;
    stray_any   = 1'b0;
    victim_idx  = '0;
    victim_page = '0;
    mvec        = '0;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      tok_vec[i]    = stat[i].tok;
      victim_vec[i] = stat[i].victim;
      mvec[i]       = stat[i].match;
      wrap_any      = wrap_any | stat[i].pass_wrap;
      stray_any     = stray_any | stat[i].stray;
      if (stat[i].victim) begin
        victim_idx  = victim_idx | IDX_W'(i);
        victim_page = victim_page | cell_page[i];
      end
    end
  end

  assign grp_bits = mvec[grp*scpr_pkg::GROUP +: scpr_pkg::GROUP];

  // Counter values after the current access
  assign req_next   = scpr_pkg::sat_inc(req_cnt);
  assign fault_next = hit_r ? fault_cnt : scpr_pkg::sat_inc(fault_cnt);
  assign disk_next  = (!hit_r && wr_r && policy_mode) ? scpr_pkg::sat_inc(disk_cnt) : disk_cnt;

  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // Sequencer, configuration, counters and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      grp           <= '0;
      filled        <= '0;
      policy_mode   <= 1'b0;
      frames_in_use <= scpr_pkg::FRAMES_RESET;
      req_cnt       <= '0;
      fault_cnt     <= '0;
      disk_cnt      <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          scpr_pkg::REG_POLICY_MODE:   policy_mode   <= cfg_data[0];
          scpr_pkg::REG_FRAMES_IN_USE: frames_in_use <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_OUT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          grp <= '0;
          if (req.valid) state <= S_MATCH;
        end
        S_MATCH: begin
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          // Walk the match bits a group at a time; the lowest frame wins
          if (|grp_bits) begin
            state <= S_TOUCH;
          end else if (grp == GW'(NG - 1)) begin
            if (filled < cap) begin
              filled <= filled + CAP_W'(1);
              state  <= S_FILL;
            end else begin
              state <= S_HAND;
            end
          end else begin
            grp <= grp + GW'(1);
          end
        end
        S_TOUCH: begin
          state <= S_OUT;
        end
        S_HAND: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (|victim_vec) state <= S_FILL;
        end
        S_FILL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            req_cnt   <= req_next;
            fault_cnt <= fault_next;
            disk_cnt  <= disk_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the access word, the chosen frame and the result word
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      key       <= PAGE_BITS'(req.data.page_number);
      wr_r      <= req.data.is_write;
      hit_r     <= 1'b0;
      evicted_r <= 1'b0;
      old_page  <= '0;
    end

    if (state == S_SEARCH) begin
      if (|grp_bits) begin
        slot  <= IDX_W'({grp, scpr_pkg::first_set(grp_bits)});
        hit_r <= 1'b1;
      end else begin
        slot <= IDX_W'(filled);
      end
    end

    if (state == S_SCAN && |victim_vec) begin
      slot      <= victim_idx;
      evicted_r <= 1'b1;
      old_page  <= victim_page;
    end

    if (state == S_OUT && out_free) begin
      rsp_data.hit               <= hit_r;
      rsp_data.frame_index       <= scpr_pkg::FRAME_W'(slot);
      rsp_data.evicted           <= evicted_r;
      rsp_data.evicted_page      <= evicted_r ? scpr_pkg::PAGE_W'(old_page) : '0;
      rsp_data.total_requests    <= req_next;
      rsp_data.total_faults      <= fault_next;
      rsp_data.total_disk_writes <= disk_next;
    end
  end

  // The clock hand sits in exactly one cell
  a_hand_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(tok_vec))
    else $error("clock hand not held by exactly one frame cell");

  // A free-frame fill comes right after the search that raised the fill level by one
  a_fill_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && !evicted_r) |-> (filled == $past(filled) + CAP_W'(1)))
    else $error("fill level did not advance on a free-frame fill");

  // A victim found by the clock walk goes straight to the fill
  a_victim_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && |victim_vec) |=> (state == S_FILL && evicted_r))
    else $error("victim not filled after clock walk");

  // Faults never outnumber requests
  a_fault_bound: assert property (@(posedge clk) disable iff (rst) fault_cnt <= req_cnt)
    else $error("fault count above request count");

endmodule

>>> design/scpr_cell.sv
// One frame cell: page tag, reference, dirty and mode bits, and a clock hand slot.
`timescale 1ns / 1ps

module scpr_cell #(
  parameter int IDX         = 0,
  parameter int PAGE_BITS   = 20,
  parameter int IDX_W       = 6,
  parameter int CAP_W       = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  scpr_pkg::cell_cmd_t   cmd,
  input  logic [PAGE_BITS-1:0]  key,
  input  logic [IDX_W-1:0]      target,
  input  logic [CAP_W-1:0]      live,
  input  logic [CAP_W-1:0]      cap,
  input  logic                  tok_in,
  output scpr_pkg::cell_stat_t  stat,
  output logic [PAGE_BITS-1:0]  page
);

  logic referenced;
  logic dirty;
  logic mode_write;
  logic match;
  logic tok;
  logic sel;
  logic skip;
  logic pass;
  logic last;

  assign sel  = (target == IDX_W'(IDX));
  assign skip = referenced | (cmd.enhanced & dirty);
  assign pass = tok & ((cmd.scan & skip) | cmd.advance);
  assign last = (32'(cap) == IDX + 1);

  // Report to the sequencer and the neighbors
  assign stat.match     = match;
  assign stat.tok       = tok;
  assign stat.pass_next = pass & ~last;
  assign stat.pass_wrap = pass & last;
  assign stat.victim    = tok & cmd.scan & ~skip;
  assign stat.stray     = tok & (32'(cap) <= IDX);

  // Hold the page tag; only frames below the fill level are ever compared
  always_ff @(posedge clk) begin
    if (cmd.fill && sel) begin
      page <= key;
    end
  end

  // Update status bits and move the clock hand
  always_ff @(posedge clk) begin
    if (rst) begin
      referenced <= 1'b0;
      dirty      <= 1'b0;
      mode_write <= 1'b0;
      match      <= 1'b0;
      tok        <= (IDX == 0);
    end else begin
      if (cmd.match_en) begin
        match <= (page == key) && (32'(live) > IDX);
      end

      if (cmd.fill && sel) begin
        referenced <= 1'b1;
        dirty      <= cmd.wr;
        mode_write <= cmd.wr;
      end else if (cmd.touch && sel) begin
        referenced <= 1'b1;
        if (mode_write != cmd.wr) begin
          mode_write <= cmd.wr;
          if (cmd.wr) dirty <= 1'b1;
        end
      end else if (cmd.scan && tok) begin
        // Second chance: drop the reference bit first, then write back dirty in the dirty-aware mode
        if (referenced) begin
          referenced <= 1'b0;
        end else if (cmd.enhanced && dirty) begin
          dirty <= 1'b0;
        end
      end

      if (cmd.tok_home) begin
        tok <= (IDX == 0);
      end else begin
        tok <= tok_in | (tok & ~pass);
      end
    end
  end

endmodule
